### hdl/hcld_pkg.sv
package hcld_pkg;

    localparam int unsigned CodeLengthDefault = 8;
    localparam int unsigned MaxCodeLength = 8;
    localparam int unsigned SampleW = 10;
    localparam int unsigned SnapW = 16;
    localparam int unsigned SumW = 20;
    localparam int unsigned CorrW = 18;
    localparam int unsigned QuotW = 21;

    localparam logic [2:0] RegMin = 3'd0;
    localparam logic [2:0] RegMax = 3'd1;
    localparam logic [2:0] RegIdeal = 3'd2;
    localparam logic [2:0] RegCode = 3'd3;
    localparam logic [2:0] RegFrame = 3'd4;

    localparam logic [1:0] SymZero = 2'd0;
    localparam logic [1:0] SymOne = 2'd1;
    localparam logic [1:0] SymUnused = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;      // snap and store the accepted sample
        logic clr_acc;    // start a new row correlation
        logic acc;        // add one chip into the row sum
        logic div_start;  // load the divider with the row sum
        logic div_step;   // one restoring division step
        logic load_out;   // capture the finished result
    } t_cmd;

endpackage

### hdl/hcld_ctrl.sv
module hcld_ctrl #(
    parameter int unsigned CODE_LENGTH = hcld_pkg::CodeLengthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output hcld_pkg::t_cmd  o_cmd,
    output logic [2:0]      o_row,
    output logic [2:0]      o_chip,
    output logic [2:0]      o_wr_idx,
    output logic            o_last
);

    localparam int unsigned DivSteps = hcld_pkg::QuotW;
    localparam logic [2:0] LastChip = 3'(CODE_LENGTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_FLUSH, S_DIVL, S_DIV, S_OUT, S_WAIT} t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_row, n_row;
    logic [2:0]  r_chip, n_chip;
    logic [4:0]  r_step, n_step;
    logic        r_valid, n_valid;
    logic        r_last, n_last;
    hcld_pkg::t_cmd w_cmd;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;
    assign o_row    = r_row;
    assign o_chip   = r_chip;
    assign o_wr_idx = r_cnt;
    assign o_last   = r_last;
    assign o_cmd    = w_cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_chip  = r_chip;
        n_step  = r_step;
        n_valid = r_valid;
        n_last  = r_last;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.store = 1'b1;
                    if (r_cnt == LastChip) begin
                        n_cnt   = '0;
                        n_row   = 3'd1;
                        n_chip  = '0;
                        n_state = S_ACC;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_ACC: begin
                w_cmd.acc = 1'b1;
                if (r_chip == 3'd0) begin
                    w_cmd.clr_acc = 1'b1;
                end
                if (r_chip == LastChip) begin
                    n_state = S_FLUSH;
                end else begin
                    n_chip = r_chip + 3'd1;
                end
            end
            // The last chip is still being added into the row sum.
            S_FLUSH: begin
                n_state = S_DIVL;
            end
            S_DIVL: begin
                w_cmd.div_start = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_step == 5'(DivSteps - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_OUT: begin
                if (!r_valid || i_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_valid = 1'b1;
                    n_last  = (r_row == LastChip);
                    if (r_row == LastChip) begin
                        n_state = S_WAIT;
                    end else begin
                        n_row   = r_row + 3'd1;
                        n_chip  = '0;
                        n_state = S_ACC;
                    end
                end else begin
                    n_valid = r_valid;
                end
            end
            S_WAIT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_valid && i_ready && !w_cmd.load_out) begin
            n_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
            r_chip  <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_chip  <= n_chip;
            r_step  <= n_step;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

endmodule

### hdl/hcld_dp.sv
module hcld_dp #(
    parameter int unsigned CODE_LENGTH = hcld_pkg::CodeLengthDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hcld_pkg::t_cmd                        i_cmd,
    input  logic [2:0]                            i_row,
    input  logic [2:0]                            i_chip,
    input  logic [2:0]                            i_wr_idx,
    input  logic                                  i_last,
    input  logic [hcld_pkg::SampleW-1:0]          i_sample,
    input  logic [9:0]                            i_min,
    input  logic [9:0]                            i_max,
    input  logic [9:0]                            i_ideal,
    input  logic [63:0]                           i_code,
    input  logic [7:0]                            i_frame_len,
    output logic [2:0]                            o_code_index,
    output logic [7:0]                            o_bit_position,
    output logic [1:0]                            o_symbol,
    output logic signed [hcld_pkg::CorrW-1:0]     o_correlation_value,
    output logic                                  o_frame_done
);

    localparam int unsigned QW = hcld_pkg::QuotW;
    localparam int signed HalfN = CODE_LENGTH;

    logic [hcld_pkg::SnapW-1:0]          r_mem [CODE_LENGTH];
    logic [hcld_pkg::SnapW-1:0]          r_rd;
    logic [hcld_pkg::SnapW-1:0]          w_snap;
    logic signed [hcld_pkg::SumW-1:0]    r_sum;
    logic                                r_bit;
    logic                                r_acc_v;
    logic                                r_first;
    logic [QW-1:0]                       r_quot;
    logic [10:0]                         r_rem;
    logic                                r_neg;
    logic [9:0]                          w_div;
    logic [10:0]                         w_trial;
    logic signed [QW:0]                  w_corr;
    logic [7:0]                          r_bitcnt;
    logic                                w_done;

    // Snap the raw sample to a multiple of the ideal level.
    always_comb begin
        logic [12:0] lo, hi;
        w_snap = {6'd0, i_sample};
        for (int i = CODE_LENGTH - 1; i >= 0; i--) begin
            lo = 13'(i) * {3'd0, i_min};
            hi = 13'(i) * {3'd0, i_max};
            if ({3'd0, i_sample} >= lo && {3'd0, i_sample} <= hi) begin
                w_snap = 16'(13'(i) * {3'd0, i_ideal});
            end
        end
    end

    // Chip buffer with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_wr_idx[$clog2(CODE_LENGTH)-1:0]] <= w_snap;
        end
        r_rd <= r_mem[i_chip[$clog2(CODE_LENGTH)-1:0]];
        r_bit <= i_code[{i_row, i_chip}];
    end

    assign w_div   = (i_ideal == 10'd0) ? 10'd1 : i_ideal;
    assign w_trial = {r_rem[9:0], r_quot[QW-1]};
    assign w_done  = (r_bitcnt + 8'd1) >= i_frame_len;
    assign w_corr  = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});

    // Row sum, then a restoring divide of -2*sum by the ideal level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v  <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            r_acc_v <= i_cmd.acc;
            if (i_cmd.load_out && i_last) begin
                r_bitcnt <= w_done ? 8'd0 : r_bitcnt + 8'd1;
            end
        end
        r_first <= i_cmd.clr_acc;
        if (r_acc_v) begin
            r_sum <= (r_first ? '0 : r_sum) + (r_bit ? -$signed({4'd0, r_rd})
                                                    : $signed({4'd0, r_rd}));
        end
        if (i_cmd.div_start) begin
            r_neg  <= ~r_sum[hcld_pkg::SumW-1] && (r_sum != '0);
            r_quot <= r_sum[hcld_pkg::SumW-1] ? QW'(-(r_sum <<< 1)) : QW'(r_sum <<< 1);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, w_div}) begin
                r_rem <= w_trial - {1'b0, w_div};
                r_quot <= {r_quot[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quot <= {r_quot[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            o_code_index        <= i_row - 3'd1;
            o_bit_position      <= r_bitcnt;
            o_correlation_value <= w_corr[hcld_pkg::CorrW-1:0];
            o_frame_done        <= w_done;
            if ((w_corr <<< 1) > HalfN) begin
                o_symbol <= hcld_pkg::SymZero;
            end else if ((w_corr <<< 1) < -HalfN) begin
                o_symbol <= hcld_pkg::SymOne;
            end else begin
                o_symbol <= hcld_pkg::SymUnused;
            end
        end
    end

endmodule

### hdl/hadamard_cdma_light_decoder.sv
// Light-sensor CDMA despreader. One ADC sample is taken per chip and snapped to
// a multiple of the ideal LED level. Samples are stored as they arrive until the last
// chip of a period; that item then produces CODE_LENGTH-1 results, one per code
// row except row 0, each through accumulate, serial divide and output steps, and
// the input is held until all of them are taken. The divider gives one bit per cycle.
module hadamard_cdma_light_decoder #(
    parameter int unsigned CODE_LENGTH = hcld_pkg::CodeLengthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [9:0]         i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_code_index,
    output logic [7:0]         o_bit_position,
    output logic [1:0]         o_symbol,
    output logic signed [17:0] o_correlation_value,
    output logic               o_last,
    output logic               o_frame_done
);

    logic [9:0]  r_min, r_max, r_ideal;
    logic [63:0] r_code;
    logic [7:0]  r_frame;
    logic [2:0]  w_idx;
    hcld_pkg::t_cmd w_cmd;
    logic [2:0]  w_row, w_chip, w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= 10'd80;
            r_max   <= 10'd160;
            r_ideal <= 10'd120;
            r_code  <= '0;
            r_frame <= 8'd8;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                hcld_pkg::RegMin:   r_min   <= pwdata[9:0];
                hcld_pkg::RegMax:   r_max   <= pwdata[9:0];
                hcld_pkg::RegIdeal: r_ideal <= pwdata[9:0];
                hcld_pkg::RegCode:  r_code  <= pwdata;
                hcld_pkg::RegFrame: r_frame <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (w_idx)
            hcld_pkg::RegMin:   prdata = {54'd0, r_min};
            hcld_pkg::RegMax:   prdata = {54'd0, r_max};
            hcld_pkg::RegIdeal: prdata = {54'd0, r_ideal};
            hcld_pkg::RegCode:  prdata = r_code;
            hcld_pkg::RegFrame: prdata = {56'd0, r_frame};
            default:            prdata = '0;
        endcase
    end

    hcld_ctrl #(.CODE_LENGTH(CODE_LENGTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(w_cmd), .o_row(w_row), .o_chip(w_chip), .o_wr_idx(w_wr), .o_last
    );

    hcld_dp #(.CODE_LENGTH(CODE_LENGTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_row(w_row), .i_chip(w_chip),
        .i_wr_idx(w_wr), .i_last(w_row == 3'(CODE_LENGTH - 1)), .i_sample,
        .i_min(r_min), .i_max(r_max), .i_ideal(r_ideal), .i_code(r_code),
        .i_frame_len(r_frame), .o_code_index, .o_bit_position, .o_symbol,
        .o_correlation_value, .o_frame_done
    );

endmodule

### hdl/hcld_checker.sv
module hcld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_symbol,
    input logic [2:0] o_code_index,
    input logic       o_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_index))
        else $error("result dropped while stalled");

    // Symbol code 3 never appears.
    a_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_symbol != 2'd3)
        else $error("bad symbol");

    // The final result of a period carries the last row.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_code_index == 3'd6)
        else $error("last on wrong row");

    // No new item is taken while results are pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken mid period");

endmodule

bind hadamard_cdma_light_decoder hcld_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_symbol, .o_code_index, .o_last
);
